[rtl/core/b64e_pkg.sv]
// shared types and the character table of the base64 stream encoder
// no dependencies; imported by every module of the encoder
`default_nettype none

package b64e_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [6:0] PAD_CHAR = 7'h3d;
	localparam logic [1:0] LAST_POS = 2'd3;

	// one group of up to three bytes handed from the front to the back
	typedef struct packed {
		logic [23:0] bits;   // first byte in the top bits, missing bytes zero
		logic [1:0]  nchr;   // index of the last real character (1..3)
		logic        final_grp;
	} b64e_group_t;

	function automatic logic [6:0] b64e_char(input logic [5:0] v);
		logic [6:0] c;
		c = '0;
		case (v) inside
			[6'd0 : 6'd25]:  c = 7'h41 + {1'b0, v};
			[6'd26 : 6'd51]: c = 7'h61 + {1'b0, v} - 7'd26;
			[6'd52 : 6'd61]: c = 7'h30 + {1'b0, v} - 7'd52;
			6'd62:           c = 7'h2b;
			default:         c = 7'h2f;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/b64e_front.sv]
// front end: gathers message bytes into groups of up to three and issues them
// depends on b64e_pkg
`default_nettype none

module b64e_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [7:0]           in_byte,
	input  wire                  in_final,
	input  wire                  q_full,
	output logic                 q_push,
	output b64e_pkg::b64e_group_t q_group
);
	import b64e_pkg::*;

	logic [7:0] pend0_q, pend1_q;
	logic [1:0] count_q;
	logic [1:0] held;
	logic [1:0] n;
	logic       take;
	logic [7:0] g0, g1, g2;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	always_comb begin
		held = (count_q >= 2'd2) ? 2'd2 : count_q;
		n    = held + 2'd1;
		g0   = (held > 2'd0) ? pend0_q : in_byte;
		g1   = (held > 2'd1) ? pend1_q : ((held == 2'd1) ? in_byte : 8'd0);
		g2   = (held == 2'd2) ? in_byte : 8'd0;
		q_group.bits      = {g0, g1, g2};
		q_group.nchr      = n;
		q_group.final_grp = in_final;
	end

	// group closes when it is full or the message ends
	assign q_push = take && (held == 2'd2 || in_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend0_q <= '0;
			pend1_q <= '0;
			count_q <= '0;
		end else if (take) begin
			if (q_push) begin
				pend0_q <= '0;
				pend1_q <= '0;
				count_q <= '0;
			end else begin
				if (held == 2'd0) pend0_q <= in_byte;
				else pend1_q <= in_byte;
				count_q <= n;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/b64e_queue.sv]
// two-entry group queue between the front end and the character serializer
// depends on b64e_pkg
`default_nettype none

module b64e_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire b64e_pkg::b64e_group_t wr_group,
	output logic                  full,
	input  wire                   pop,
	output logic                  not_empty,
	output b64e_pkg::b64e_group_t rd_group
);
	import b64e_pkg::*;

	b64e_group_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]    count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign rd_group  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_group;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/b64e_back.sv]
// back end: turns each queued group into four characters, one per cycle while out_ready is high
// depends on b64e_pkg
`default_nettype none

module b64e_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   q_not_empty,
	input  wire b64e_pkg::b64e_group_t q_group,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [6:0]            out_char,
	output logic                  out_last
);
	import b64e_pkg::*;

	logic [1:0] pos_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       last_q;
	logic       load;
	logic [5:0] sext;
	logic [6:0] next_char;

	// output register frees up when empty or being taken
	assign load  = q_not_empty && (!valid_q || out_ready);
	assign q_pop = load && (pos_q == LAST_POS);

	always_comb begin
		case (pos_q)
			2'd0:    sext = q_group.bits[23:18];
			2'd1:    sext = q_group.bits[17:12];
			2'd2:    sext = q_group.bits[11:6];
			default: sext = q_group.bits[5:0];
		endcase
		next_char = (pos_q > q_group.nchr) ? PAD_CHAR : b64e_char(sext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) pos_q <= pos_q + 2'd1;
			if (load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= next_char;
			last_q <= (pos_q == LAST_POS) && q_group.final_grp;
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

[rtl/core/base64_stream_encoder_unit.sv]
// base64 stream encoder top level: front end, group queue, serializer
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
//
// usage:
//   slave side takes one message byte per transfer in s_tdata, s_tlast
//   marks the final byte of a message. master side gives one ascii
//   character per transfer in m_tdata[6:0], m_tlast marks the final
//   character of the encoded message.
//   every third byte, or a final byte, closes a group; each group yields
//   exactly four characters, missing bytes count as zero and the unused
//   character slots are '=' padding.
//   with the serializer idle, the group closed by a byte is first written
//   into the queue, then its first character is loaded into the output
//   register. the serializer gives one character per cycle while groups
//   are queued and m_tready is high; bytes that only fill a group are held.
//   a two-group queue sits between the front end and the serializer; the
//   front keeps taking bytes while the receiver stalls until that queue
//   fills, then s_tready drops. reset empties the queue, clears the held
//   bytes and drops m_tvalid.
`default_nettype none

module base64_stream_encoder_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] data_byte
	input  wire        s_tlast,   // is_final
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
	output logic       m_tlast    // is_last_char
);
	import b64e_pkg::*;

	b64e_group_t push_group, head_group;
	logic        q_push, q_full, q_pop, q_not_empty;
	logic [6:0]  out_char;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_final (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_group  (push_group)
	);

	b64e_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_group  (push_group),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_group  (head_group)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_group     (head_group),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_char    (out_char),
		.out_last    (m_tlast)
	);

	assign m_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

[rtl/core/b64e_checker.sv]
// port-level checks of the base64 stream encoder, bound to the top level
// depends on b64e_pkg and base64_stream_encoder_unit
`default_nettype none

module b64e_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tlast
);
	import b64e_pkg::*;

	logic [1:0] beat_q;
	logic       m_xfer;

	assign m_xfer = m_tvalid && m_tready;

	// position of the next output character within its group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) beat_q <= '0;
		else if (m_xfer) beat_q <= beat_q + 2'd1;
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("master payload changed during stall");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> beat_q == 2'd3)
		else $error("tlast outside the fourth character of a group");

	a_pad_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (beat_q == 2'd0 || beat_q == 2'd1) |-> m_tdata != {1'b0, PAD_CHAR})
		else $error("padding in the first two characters of a group");

	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer && beat_q == 2'd2 && m_tdata == {1'b0, PAD_CHAR} ##1 m_tvalid
		|-> m_tdata == {1'b0, PAD_CHAR})
		else $error("padding not followed by padding");

	a_top_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[7])
		else $error("non-ascii character on master side");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
